// ----- design/ntir_pkg.sv -----
// Shared types and constants for the name-to-id registry.
// Used by the front queue, the search back end and the top level.
package ntir_pkg;

    localparam int KEY_W    = 64;
    localparam int ID_W     = 8;
    localparam int FUNC_W   = 2;
    localparam int STATUS_W = 2;
    localparam int DATA_W   = ID_W + KEY_W;

    localparam logic [FUNC_W-1:0] FUNC_REGISTER = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_LOOKUP   = 2'd1;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_INVALID   = 2'd3;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [KEY_W-1:0]  key;
        logic [ID_W-1:0]   tid;
    } cmd_t;

    typedef enum logic {
        BK_IDLE,
        BK_SCAN
    } back_state_t;

endpackage

// ----- design/name_to_id_registry.sv -----
// Name-to-id registry: a request is registered into the front queue, then the back
// end scans the used entries one per cycle through the table RAM's single read port.
// A scan reads at most used_count entries, at most ENTRIES. The back end takes a new
// register or lookup only once the previous scan has ended and its result has been
// popped. An invalid code is answered from the idle state without a scan.
// Reset clears the queues and the used count; the table RAM itself is not cleared.
module name_to_id_registry #(
    parameter int ENTRIES    = 32,
    parameter int NAME_BYTES = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [ntir_pkg::FUNC_W-1:0]   func,
    input  logic [ntir_pkg::KEY_W-1:0]    name_key,
    input  logic [ntir_pkg::ID_W-1:0]     task_id,
    output logic                          empty,
    input  logic                          pop,
    output logic [ntir_pkg::STATUS_W-1:0] status,
    output logic [ntir_pkg::ID_W-1:0]     found_id
);

    localparam int CNT_W = $clog2(ENTRIES + 1);

    logic             cmd_valid, cmd_take, res_valid;
    ntir_pkg::cmd_t   cmd;
    logic [1:0]       fq_level;
    logic [CNT_W-1:0] used_count;

    ntir_front #(
        .NAME_BYTES (NAME_BYTES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .func      (func),
        .name_key  (name_key),
        .task_id   (task_id),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take),
        .level     (fq_level)
    );

    ntir_back #(
        .ENTRIES (ENTRIES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .cmd_take   (cmd_take),
        .res_valid  (res_valid),
        .res_pop    (pop),
        .res_status (status),
        .res_id     (found_id),
        .used_count (used_count)
    );

    assign empty = !res_valid;

    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_count <= CNT_W'(ENTRIES))
        else $error("used count beyond table size");

    a_used_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (used_count == $past(used_count)) || (used_count == $past(used_count) + CNT_W'(1)))
        else $error("used count moved by more than one append");

    a_queue_level: assert property (@(posedge clk) disable iff (!rst_n)
        fq_level <= 2'd2)
        else $error("front queue level out of range");

endmodule

// ----- design/ntir_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ntir_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- design/ntir_front.sv -----
// Request front end: masks the name key and holds requests in a two-word queue.
// Depends on ntir_pkg.
module ntir_front #(
    parameter int NAME_BYTES = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [ntir_pkg::FUNC_W-1:0]   func,
    input  logic [ntir_pkg::KEY_W-1:0]    name_key,
    input  logic [ntir_pkg::ID_W-1:0]     task_id,
    output logic                          cmd_valid,
    output ntir_pkg::cmd_t                cmd,
    input  logic                          cmd_take,
    output logic [1:0]                    level
);

    localparam logic [ntir_pkg::KEY_W-1:0] KEY_MASK =
        (NAME_BYTES >= 8) ? {ntir_pkg::KEY_W{1'b1}}
                          : ((ntir_pkg::KEY_W'(1) << (8 * NAME_BYTES)) - ntir_pkg::KEY_W'(1));

    ntir_pkg::cmd_t slot_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     count_reg, count_next;
    logic           do_push, do_pop;
    ntir_pkg::cmd_t in_cmd;

    assign full      = (count_reg == 2'd2);
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = slot_reg[rd_ptr_reg];
    assign level     = count_reg;

    assign do_push = push && !full;
    assign do_pop  = cmd_take && cmd_valid;

    always_comb
    begin
        in_cmd.func = func;
        in_cmd.key  = name_key & KEY_MASK;
        in_cmd.tid  = task_id;
    end

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

// ----- design/ntir_back.sv -----
// Search back end: scans the entry table one entry per cycle, updates it and
// holds the result word. Depends on ntir_pkg and ntir_ram.
module ntir_back #(
    parameter int ENTRIES = 32,
    localparam int CNT_W  = $clog2(ENTRIES + 1),
    localparam int IDX_W  = $clog2(ENTRIES)
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cmd_valid,
    input  ntir_pkg::cmd_t                  cmd,
    output logic                            cmd_take,
    output logic                            res_valid,
    input  logic                            res_pop,
    output logic [ntir_pkg::STATUS_W-1:0]   res_status,
    output logic [ntir_pkg::ID_W-1:0]       res_id,
    output logic [CNT_W-1:0]                used_count
);

    localparam logic [CNT_W-1:0] ENTRY_CNT = CNT_W'(ENTRIES);

    ntir_pkg::back_state_t state_reg, state_next;
    ntir_pkg::cmd_t        cur_reg, cur_next;
    logic [CNT_W-1:0]      idx_reg, idx_next;
    logic [CNT_W-1:0]      used_reg, used_next;
    logic                  pend_reg, pend_next;
    logic [IDX_W-1:0]      pend_idx_reg, pend_idx_next;
    logic                  res_valid_reg, res_valid_next;
    logic [ntir_pkg::STATUS_W-1:0] res_status_reg, res_status_next;
    logic [ntir_pkg::ID_W-1:0]     res_id_reg, res_id_next;

    logic                          rd_en, wr_en;
    logic [IDX_W-1:0]              rd_addr, wr_addr;
    logic [ntir_pkg::DATA_W-1:0]   wr_data, rd_data;
    logic                          valid_func, hit, scan_more;

    ntir_ram #(
        .WIDTH (ntir_pkg::DATA_W),
        .DEPTH (ENTRIES)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign valid_func = (cmd.func == ntir_pkg::FUNC_REGISTER) ||
                        (cmd.func == ntir_pkg::FUNC_LOOKUP);
    // Data of the previous read is compared while the next one is issued.
    assign hit        = pend_reg && (rd_data[ntir_pkg::KEY_W-1:0] == cur_reg.key);
    assign scan_more  = (idx_reg != used_reg);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ntir_pkg::BK_IDLE:
            begin
                if (cmd_valid && !res_valid_reg && valid_func)
                begin
                    state_next = ntir_pkg::BK_SCAN;
                end
            end
            ntir_pkg::BK_SCAN:
            begin
                if (hit || !scan_more)
                begin
                    state_next = ntir_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = ntir_pkg::BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd_take        = 1'b0;
        cur_next        = cur_reg;
        idx_next        = idx_reg;
        used_next       = used_reg;
        pend_next       = pend_reg;
        pend_idx_next   = pend_idx_reg;
        res_valid_next  = res_valid_reg;
        res_status_next = res_status_reg;
        res_id_next     = res_id_reg;
        rd_en           = 1'b0;
        rd_addr         = idx_reg[IDX_W-1:0];
        wr_en           = 1'b0;
        wr_addr         = pend_idx_reg;
        wr_data         = {cur_reg.tid, cur_reg.key};

        if (res_pop && res_valid_reg)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            ntir_pkg::BK_IDLE:
            begin
                if (cmd_valid && !res_valid_reg)
                begin
                    cmd_take  = 1'b1;
                    cur_next  = cmd;
                    idx_next  = '0;
                    pend_next = 1'b0;
                    if (!valid_func)
                    begin
                        res_valid_next  = 1'b1;
                        res_status_next = ntir_pkg::ST_INVALID;
                        res_id_next     = '0;
                    end
                end
            end
            ntir_pkg::BK_SCAN:
            begin
                if (hit)
                begin
                    pend_next      = 1'b0;
                    res_valid_next = 1'b1;
                    res_status_next = ntir_pkg::ST_OK;
                    if (cur_reg.func == ntir_pkg::FUNC_REGISTER)
                    begin
                        // overwrite the id of the matching entry
                        wr_en       = 1'b1;
                        wr_addr     = pend_idx_reg;
                        res_id_next = '0;
                    end
                    else
                    begin
                        res_id_next = rd_data[ntir_pkg::DATA_W-1:ntir_pkg::KEY_W];
                    end
                end
                else if (scan_more)
                begin
                    rd_en         = 1'b1;
                    pend_next     = 1'b1;
                    pend_idx_next = idx_reg[IDX_W-1:0];
                    idx_next      = idx_reg + CNT_W'(1);
                end
                else
                begin
                    pend_next      = 1'b0;
                    res_valid_next = 1'b1;
                    res_id_next    = '0;
                    if (cur_reg.func == ntir_pkg::FUNC_REGISTER)
                    begin
                        if (used_reg != ENTRY_CNT)
                        begin
                            // append at the next free slot
                            wr_en           = 1'b1;
                            wr_addr         = used_reg[IDX_W-1:0];
                            used_next       = used_reg + CNT_W'(1);
                            res_status_next = ntir_pkg::ST_OK;
                        end
                        else
                        begin
                            res_status_next = ntir_pkg::ST_FULL;
                        end
                    end
                    else
                    begin
                        res_status_next = ntir_pkg::ST_NOT_FOUND;
                    end
                end
            end
            default:
            begin
                pend_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ntir_pkg::BK_IDLE;
            used_reg      <= '0;
            pend_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            pend_reg      <= pend_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg        <= cur_next;
        idx_reg        <= idx_next;
        pend_idx_reg   <= pend_idx_next;
        res_status_reg <= res_status_next;
        res_id_reg     <= res_id_next;
    end

    assign res_valid  = res_valid_reg;
    assign res_status = res_status_reg;
    assign res_id     = res_id_reg;
    assign used_count = used_reg;

endmodule
